// File: src/bit_vector_edit_distance_search_macros.svh
`ifndef BIT_VECTOR_EDIT_DISTANCE_SEARCH_MACROS_SVH
`define BIT_VECTOR_EDIT_DISTANCE_SEARCH_MACROS_SVH

// condition holds in the same cycle as the trigger
`define BVEDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define BVEDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bveds_pkg.sv
`default_nettype none

package bveds_pkg;

    localparam int PATTERN_MAX_DEFAULT = 64;
    localparam int REF_MAX             = 1024;
    localparam int POS_W               = $clog2(REF_MAX);
    localparam int CHAR_W              = 8;
    localparam int LEN_W               = 7;
    localparam int DIST_W              = 7;
    localparam int CFG_DATA_W          = 64;
    localparam int REG_IDX_W           = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PLANE_LOW  = 2'd0,
        REG_PLANE_HIGH = 2'd1,
        REG_LENGTH     = 2'd2
    } reg_index_t;

endpackage

`default_nettype wire

// File: src/bveds_ref_if.sv
`default_nettype none

interface bveds_ref_if
    import bveds_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ref_char;
    logic              last;

    modport source (output valid, output ref_char, output last, input ready);
    modport sink   (input valid, input ref_char, input last, output ready);
endinterface

`default_nettype wire

// File: src/bveds_res_if.sv
`default_nettype none

interface bveds_res_if
    import bveds_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  end_position;
    logic [DIST_W-1:0] best_distance;

    modport source (output valid, output end_position, output best_distance, input ready);
    modport sink   (input valid, input end_position, input best_distance, output ready);
endinterface

`default_nettype wire

// File: src/bveds_cfg_if.sv
`default_nettype none

interface bveds_cfg_if
    import bveds_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: src/bit_vector_edit_distance_search.sv
`default_nettype none
`include "bit_vector_edit_distance_search_macros.svh"

// Approximate pattern search over a streamed reference, one base per transaction, by the
// Myers bit-vector method. The pattern (up to PATTERN_MAX bases, two bit planes plus a length)
// is loaded through cfg; any write to a defined register restarts the scoring. Each character
// is reduced to its bits 1 and 2. A new character is taken every cycle unless the input is
// stalled: it is captured in an input register, from which one bit-vector step (a
// PATTERN_MAX-bit add and the score update) updates the column state. On the character
// marked last, the smallest distance and the first reference index where it was reached
// go to the result register as that character leaves the input register; the result register
// and input register let input keep flowing while a result waits, so the sink stalls the
// input only when a second result would overtake a pending one. Indices saturate at REF_MAX-1.
module bit_vector_edit_distance_search
    import bveds_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
    input  wire          clk,
    input  wire          rst_n,
    bveds_ref_if.sink    ref_stream,
    bveds_res_if.source  result,
    bveds_cfg_if.sink    cfg
);

    localparam int PM      = PATTERN_MAX;
    localparam int SCORE_W = $clog2(PM + 1);
    localparam int IDX_W   = (PM > 1) ? $clog2(PM) : 1;

    function automatic logic [SCORE_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [SCORE_W-1:0] m;
        if (len == '0)
            m = SCORE_W'(1);
        else if (len > LEN_W'(PM))
            m = SCORE_W'(PM);
        else
            m = len[SCORE_W-1:0];
        return m;
    endfunction

    function automatic logic [PM-1:0] len_mask(input logic [SCORE_W-1:0] m);
        logic [PM-1:0] mask;
        for (int i = 0; i < PM; i++)
            mask[i] = (SCORE_W'(i) < m);
        return mask;
    endfunction

    // pattern registers
    logic [PM-1:0]    plane_low_reg,  plane_low_next;
    logic [PM-1:0]    plane_high_reg, plane_high_next;
    logic [LEN_W-1:0] len_reg,        len_next;

    // input register
    logic             stage_valid_reg, stage_valid_next;
    logic [1:0]       stage_code_reg,  stage_code_next;
    logic             stage_last_reg,  stage_last_next;

    // column state
    logic [PM-1:0]      vp_reg,    vp_next;
    logic [PM-1:0]      vn_reg,    vn_next;
    logic [SCORE_W-1:0] run_reg,   run_next;
    logic [SCORE_W-1:0] best_reg,  best_next;
    logic [POS_W-1:0]   bidx_reg,  bidx_next;
    logic [POS_W-1:0]   ridx_reg,  ridx_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg,   out_pos_next;
    logic [DIST_W-1:0]  out_dist_reg,  out_dist_next;

    logic               cfg_wr, cfg_restart;
    logic               in_acc, stage_go, out_free;
    logic [SCORE_W-1:0] m, m_minus, restart_m;
    logic [IDX_W-1:0]   top_idx;
    logic [PM-1:0]      lm, restart_lm;
    logic [PM-1:0]      code_b1, code_b2, eq, vp, vn, xv, d0, hn, hp, xh;
    logic               top_hp, top_hn;
    logic [SCORE_W-1:0] score;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    assign out_free         = !out_valid_reg || result.ready;
    assign stage_go         = stage_valid_reg && (!stage_last_reg || out_free);
    assign ref_stream.ready = !stage_valid_reg || stage_go;
    assign in_acc           = ref_stream.valid && ref_stream.ready;

    assign result.valid         = out_valid_reg;
    assign result.end_position  = out_pos_reg;
    assign result.best_distance = out_dist_reg;

    // bit-vector step
    always_comb
    begin
        m       = eff_len(len_reg);
        lm      = len_mask(m);
        m_minus = m - SCORE_W'(1);
        top_idx = m_minus[IDX_W-1:0];
        code_b1 = {PM{stage_code_reg[0]}};
        code_b2 = {PM{stage_code_reg[1]}};
        eq      = ~(plane_low_reg ^ code_b1) & ~(plane_high_reg ^ code_b2) & lm;
        vp      = vp_reg & lm;
        vn      = vn_reg & lm;
        xv      = eq | vn;
        d0      = ((((xv & vp) + vp) ^ vp) | xv) & lm;
        hn      = d0 & vp;
        hp      = (vn | ~(d0 | vp)) & lm;
        top_hp  = hp[top_idx];
        top_hn  = hn[top_idx];
        xh      = (hp << 1) & lm;

        if (top_hp && !top_hn)
            score = (run_reg >= m) ? m : run_reg + SCORE_W'(1);
        else if (top_hn && !top_hp)
            score = (run_reg == '0) ? '0 : run_reg - SCORE_W'(1);
        else
            score = (run_reg > m) ? m : run_reg;
    end

    // configuration decode and restart length
    always_comb
    begin
        plane_low_next  = plane_low_reg;
        plane_high_next = plane_high_reg;
        len_next        = len_reg;
        cfg_restart     = 1'b0;
        if (cfg_wr)
        begin
            unique case (reg_index_t'(cfg.reg_index))
                REG_PLANE_LOW:
                begin
                    plane_low_next = cfg.wdata[PM-1:0];
                    cfg_restart    = 1'b1;
                end
                REG_PLANE_HIGH:
                begin
                    plane_high_next = cfg.wdata[PM-1:0];
                    cfg_restart     = 1'b1;
                end
                REG_LENGTH:
                begin
                    len_next    = cfg.wdata[LEN_W-1:0];
                    cfg_restart = 1'b1;
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
        restart_m  = eff_len(len_next);
        restart_lm = len_mask(restart_m);
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_code_next  = stage_code_reg;
        stage_last_next  = stage_last_reg;
        if (in_acc)
        begin
            stage_valid_next = 1'b1;
            stage_code_next  = ref_stream.ref_char[2:1];
            stage_last_next  = ref_stream.last;
        end
        else if (stage_go)
        begin
            stage_valid_next = 1'b0;
        end

        vp_next   = vp_reg;
        vn_next   = vn_reg;
        run_next  = run_reg;
        best_next = best_reg;
        bidx_next = bidx_reg;
        ridx_next = ridx_reg;

        out_valid_next = out_valid_reg && !result.ready;
        out_pos_next   = out_pos_reg;
        out_dist_next  = out_dist_reg;

        if (cfg_restart || (stage_go && stage_last_reg))
        begin
            vp_next   = restart_lm;
            vn_next   = '0;
            run_next  = restart_m;
            best_next = restart_m;
            bidx_next = '0;
            ridx_next = '0;
        end
        else if (stage_go)
        begin
            vn_next  = xh & d0;
            vp_next  = ((hn << 1) | ~(xh | d0)) & lm;
            run_next = score;
            if (score < best_reg)
            begin
                best_next = score;
                bidx_next = ridx_reg;
            end
            if (ridx_reg != POS_W'(REF_MAX - 1))
                ridx_next = ridx_reg + POS_W'(1);
        end

        // the reported best includes this character's own score
        if (stage_go && stage_last_reg)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = (score < best_reg) ? ridx_reg : bidx_reg;
            out_dist_next  = DIST_W'((score < best_reg) ? score : best_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_low_reg   <= '0;
            plane_high_reg  <= '0;
            len_reg         <= LEN_W'(1);
            stage_valid_reg <= 1'b0;
            vp_reg          <= PM'(1);
            vn_reg          <= '0;
            run_reg         <= SCORE_W'(1);
            best_reg        <= SCORE_W'(1);
            bidx_reg        <= '0;
            ridx_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            plane_low_reg   <= plane_low_next;
            plane_high_reg  <= plane_high_next;
            len_reg         <= len_next;
            stage_valid_reg <= stage_valid_next;
            vp_reg          <= vp_next;
            vn_reg          <= vn_next;
            run_reg         <= run_next;
            best_reg        <= best_next;
            bidx_reg        <= bidx_next;
            ridx_reg        <= ridx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_code_reg <= stage_code_next;
        stage_last_reg <= stage_last_next;
        out_pos_reg    <= out_pos_next;
        out_dist_reg   <= out_dist_next;
    end

    `BVEDS_ASSERT_NOW(a_vert_disjoint, clk, rst_n, 1'b1, (vp_reg & vn_reg) == '0,
        "vertical plus and minus overlap")
    `BVEDS_ASSERT_NOW(a_best_le_run, clk, rst_n, 1'b1, best_reg <= run_reg,
        "best score above running score")
    `BVEDS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, stage_go && stage_last_reg,
        out_valid_reg, "last character did not produce a result")
    `BVEDS_ASSERT_NEXT(a_last_restarts, clk, rst_n, stage_go && stage_last_reg,
        ridx_reg == '0 && vn_reg == '0, "state not restarted after last character")

endmodule

`default_nettype wire
